[rtl/core/cprc_pkg.sv]
// Shared types and constants of the polar/rectangular CORDIC converter.
// Used by cprc_pre, cprc_cell, cprc_post and complex_polar_rectangular_convert.
package cprc_pkg;

  // micro-rotation count, limited by the angle table
  localparam int unsigned ITERATIONS = 16;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned ITER_RUN   = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

  // field widths
  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT1_W = 17;
  localparam int unsigned OUT2_W = 16;

  // datapath widths: coordinates carry 14 guard bits, angles are degrees Q.16
  localparam int unsigned GUARD  = 14;
  localparam int unsigned XW     = 33;
  localparam int unsigned ZW     = 27;
  localparam int unsigned SHW    = 5;
  localparam int unsigned GAIN_W = 25;
  localparam int unsigned PW     = XW + GAIN_W;
  localparam int unsigned UNSC   = 24 + GUARD;
  localparam int unsigned RW     = PW - UNSC;

  // constants
  localparam logic signed [GAIN_W-1:0] GAIN_Q24   = 25'sd10188014;
  localparam logic signed [ZW-1:0]     DEG180_Q16 = 27'sd11796480;
  localparam logic signed [ZW-1:0]     DEG90_Q16  = 27'sd5898240;
  localparam logic signed [IN_W-1:0]   ANG_LIM_Q6 = 16'sd11520;
  localparam logic signed [RW-1:0]     MAG_MAX    = 20'sd46341;
  localparam logic signed [RW-1:0]     IM_MAX     = 20'sd32767;
  localparam logic signed [RW-1:0]     IM_MIN     = -20'sd32768;

  // atan(2^-i) in degrees Q.16, rounded to nearest
  localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  // one beat in flight through the rotation chain
  typedef struct packed {
    logic                 vld;
    logic                 mode;   // 0 vectoring (to polar), 1 rotation (to rectangular)
    logic                 zero;   // zero vector in mode 0
    logic                 neg;    // angle was folded, negate result
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } stage_t;

endpackage

[rtl/core/cprc_pre.sv]
// Input stage: maps a beat onto the CORDIC start vector and angle.
// Depends on cprc_pkg.
module cprc_pre (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic                   mode_i,
  input  logic signed [15:0]     first_i,
  input  logic signed [15:0]     second_i,
  output cprc_pkg::stage_t       stage_o
);

  cprc_pkg::stage_t st_d, st_q;

  logic signed [cprc_pkg::XW-1:0]   a_sh, b_sh;
  logic signed [cprc_pkg::IN_W-1:0] b_cl;
  logic signed [cprc_pkg::ZW-1:0]   z_rot;

  // start values for both modes
  always_comb begin
    a_sh  = cprc_pkg::XW'(first_i) <<< cprc_pkg::GUARD;
    b_sh  = cprc_pkg::XW'(second_i) <<< cprc_pkg::GUARD;
    b_cl  = second_i;
    if (second_i > cprc_pkg::ANG_LIM_Q6) begin
      b_cl = cprc_pkg::ANG_LIM_Q6;
    end else if (second_i < -cprc_pkg::ANG_LIM_Q6) begin
      b_cl = -cprc_pkg::ANG_LIM_Q6;
    end
    z_rot = cprc_pkg::ZW'(b_cl) <<< 10;

    st_d      = '0;
    st_d.vld  = vld_i;
    st_d.mode = mode_i;
    if (!mode_i) begin
      st_d.zero = (first_i == '0) && (second_i == '0);
      if (first_i < 0) begin
        // left half plane: turn by 180 degrees
        st_d.x = -a_sh;
        st_d.y = -b_sh;
        st_d.z = (second_i >= 0) ? cprc_pkg::DEG180_Q16 : -cprc_pkg::DEG180_Q16;
      end else begin
        st_d.x = a_sh;
        st_d.y = b_sh;
        st_d.z = '0;
      end
    end else begin
      st_d.x = a_sh;
      st_d.y = '0;
      st_d.z = z_rot;
      // fold angles beyond +-90 degrees
      if (z_rot > cprc_pkg::DEG90_Q16) begin
        st_d.z   = z_rot - cprc_pkg::DEG180_Q16;
        st_d.neg = 1'b1;
      end else if (z_rot < -cprc_pkg::DEG90_Q16) begin
        st_d.z   = z_rot + cprc_pkg::DEG180_Q16;
        st_d.neg = 1'b1;
      end
    end
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;

endmodule

[rtl/core/cprc_cell.sv]
// One CORDIC micro-rotation cell with its pipeline register.
// Depends on cprc_pkg; shift and angle come from the chain position.
module cprc_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [cprc_pkg::SHW-1:0]        shift_i,
  input  logic signed [cprc_pkg::ZW-1:0]  atan_i,
  input  cprc_pkg::stage_t                stage_i,
  output cprc_pkg::stage_t                stage_o
);

  cprc_pkg::stage_t st_d, st_q;

  logic signed [cprc_pkg::XW-1:0] dx, dy;
  logic                           ccw;

  // rotate toward y = 0 (mode 0) or z = 0 (mode 1)
  always_comb begin
    dx   = stage_i.y >>> shift_i;
    dy   = stage_i.x >>> shift_i;
    ccw  = stage_i.mode ? !stage_i.z[cprc_pkg::ZW-1] : stage_i.y[cprc_pkg::XW-1];
    st_d = stage_i;
    if (ccw) begin
      st_d.x = stage_i.x - dx;
      st_d.y = stage_i.y + dy;
      st_d.z = stage_i.z - atan_i;
    end else begin
      st_d.x = stage_i.x + dx;
      st_d.y = stage_i.y - dy;
      st_d.z = stage_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;

endmodule

[rtl/core/cprc_post.sv]
// Output stages: sign fix, gain removal multiply, rounding and saturation.
// Depends on cprc_pkg. Three register stages.
module cprc_post (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  cprc_pkg::stage_t                    stage_i,
  output logic                                vld_o,
  output logic signed [cprc_pkg::OUT1_W-1:0]  first_o,
  output logic signed [cprc_pkg::OUT2_W-1:0]  second_o
);

  localparam logic signed [cprc_pkg::PW-1:0] RND = cprc_pkg::PW'(1) <<< (cprc_pkg::UNSC - 1);

  // stage A: negate folded results, round the angle
  logic                             a_vld_q, a_mode_q, a_zero_q;
  logic signed [cprc_pkg::XW-1:0]   a_x_q, a_y_q;
  logic signed [cprc_pkg::ZW-1:0]   a_z_q;
  // stage B: gain products
  logic                             b_vld_q, b_mode_q, b_zero_q;
  logic signed [cprc_pkg::PW-1:0]   b_px_q, b_py_q;
  logic signed [cprc_pkg::ZW-1:0]   b_z_q;
  // stage C: results
  logic                             c_vld_q;
  logic signed [cprc_pkg::OUT1_W-1:0] c_first_q, c_first_d;
  logic signed [cprc_pkg::OUT2_W-1:0] c_second_q, c_second_d;

  logic signed [cprc_pkg::RW-1:0]   rx, ry;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= stage_i.vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // stage A
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mode_q <= stage_i.mode;
      a_zero_q <= stage_i.zero;
      a_x_q    <= stage_i.neg ? -stage_i.x : stage_i.x;
      a_y_q    <= stage_i.neg ? -stage_i.y : stage_i.y;
      a_z_q    <= (stage_i.z + cprc_pkg::ZW'(512)) >>> 10;
    end
  end

  // stage B
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_mode_q <= a_mode_q;
      b_zero_q <= a_zero_q;
      b_px_q   <= cprc_pkg::PW'(a_x_q) * cprc_pkg::PW'(cprc_pkg::GAIN_Q24);
      b_py_q   <= cprc_pkg::PW'(a_y_q) * cprc_pkg::PW'(cprc_pkg::GAIN_Q24);
      b_z_q    <= a_z_q;
    end
  end

  // round to nearest, then saturate per mode
  always_comb begin
    rx = cprc_pkg::RW'((b_px_q + RND) >>> cprc_pkg::UNSC);
    ry = cprc_pkg::RW'((b_py_q + RND) >>> cprc_pkg::UNSC);
    c_first_d  = '0;
    c_second_d = '0;
    if (!b_mode_q) begin
      if (!b_zero_q) begin
        if (rx < 0) begin
          c_first_d = '0;
        end else if (rx > cprc_pkg::MAG_MAX) begin
          c_first_d = cprc_pkg::OUT1_W'(cprc_pkg::MAG_MAX);
        end else begin
          c_first_d = cprc_pkg::OUT1_W'(rx);
        end
        if (b_z_q > cprc_pkg::ZW'(cprc_pkg::ANG_LIM_Q6)) begin
          c_second_d = cprc_pkg::ANG_LIM_Q6;
        end else if (b_z_q < -cprc_pkg::ZW'(cprc_pkg::ANG_LIM_Q6)) begin
          c_second_d = -cprc_pkg::ANG_LIM_Q6;
        end else begin
          c_second_d = cprc_pkg::OUT2_W'(b_z_q);
        end
      end
    end else begin
      if (rx > cprc_pkg::MAG_MAX) begin
        c_first_d = cprc_pkg::OUT1_W'(cprc_pkg::MAG_MAX);
      end else if (rx < -cprc_pkg::MAG_MAX) begin
        c_first_d = -cprc_pkg::OUT1_W'(cprc_pkg::MAG_MAX);
      end else begin
        c_first_d = cprc_pkg::OUT1_W'(rx);
      end
      if (ry > cprc_pkg::IM_MAX) begin
        c_second_d = cprc_pkg::OUT2_W'(cprc_pkg::IM_MAX);
      end else if (ry < cprc_pkg::IM_MIN) begin
        c_second_d = cprc_pkg::OUT2_W'(cprc_pkg::IM_MIN);
      end else begin
        c_second_d = cprc_pkg::OUT2_W'(ry);
      end
    end
  end

  // stage C
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_first_q  <= c_first_d;
      c_second_q <= c_second_d;
    end
  end

  assign vld_o    = c_vld_q;
  assign first_o  = c_first_q;
  assign second_o = c_second_q;

endmodule

[rtl/core/complex_polar_rectangular_convert.sv]
// Top level of the polar/rectangular CORDIC converter: input stage, rotation
// chain of cprc_cell, cprc_post and the output register with skid buffer.
// Depends on cprc_pkg, cprc_pre, cprc_cell, cprc_post.
//
//  channel  | dir | fields (lsb first)                       | handshake
//  ---------+-----+------------------------------------------+--------------------------
//  s_axis   | in  | tdata: in_first, in_second; tuser: mode  | tvalid/tready
//  m_axis   | out | tdata: out_first, out_second, zero fill  | tvalid/tready
//
// One beat is taken every cycle while the skid register is empty. The path is
// one input stage, one cell per rotation, three post stages and the output
// register. Reset clears every valid bit; no data needs clearing.
// When the sink stalls, the skid register takes one more beat and the whole
// chain then holds until the skid drains.
module complex_polar_rectangular_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] in_first, [31:16] in_second
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [16:0] out_first, [32:17] out_second, [39:33] zero
);

  logic en;

  cprc_pkg::stage_t chain [cprc_pkg::ITER_RUN+1];

  logic                                post_vld;
  logic signed [cprc_pkg::OUT1_W-1:0]  post_first;
  logic signed [cprc_pkg::OUT2_W-1:0]  post_second;

  logic        out_vld_q, skid_vld_q;
  logic [39:0] out_data_q, skid_data_q, post_data;
  logic        incoming, take;

  // chain advances while the skid register is free
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  cprc_pre u_pre (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s_axis_tvalid),
    .mode_i   (s_axis_tuser),
    .first_i  (s_axis_tdata[15:0]),
    .second_i (s_axis_tdata[31:16]),
    .stage_o  (chain[0])
  );

  // rotation chain, one cell per iteration
  for (genvar g = 0; g < cprc_pkg::ITER_RUN; g++) begin : g_cell
    cprc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (cprc_pkg::SHW'(g)),
      .atan_i  (cprc_pkg::ATAN_DEG_Q16[g]),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  cprc_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .stage_i  (chain[cprc_pkg::ITER_RUN]),
    .vld_o    (post_vld),
    .first_o  (post_first),
    .second_o (post_second)
  );

  assign post_data = {7'd0, post_second, post_first};
  assign incoming  = en && post_vld;
  assign take      = !out_vld_q || m_axis_tready;

  // output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= incoming;
      end
    end else if (incoming) begin
      skid_vld_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= skid_vld_q ? skid_data_q : post_data;
    end else if (incoming) begin
      skid_data_q <= post_data;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // skid only fills behind a held output beat
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a beat while output register is empty");

  // a full skid blocks the input
  a_skid_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !s_axis_tready)
    else $error("input open while skid register is full");

  // skid drains only when the sink took the output beat
  a_skid_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_vld_q) |-> $past(m_axis_tready) && out_vld_q)
    else $error("skid drained without an output transfer");

endmodule

[bench/polar_rect_check_pkg.sv]
// Conversion predictor and result scoreboard for the polar/rectangular
// CORDIC converter bench. Depends on cprc_pkg for the rotation count and guard bits.
package polar_rect_check_pkg;

  // rotations actually run; the angle table stops at 24 entries
  localparam int ATAN_LEN  = 24;
  localparam int ROTATIONS = (cprc_pkg::ITERATIONS < ATAN_LEN) ? cprc_pkg::ITERATIONS : ATAN_LEN;
  localparam int GUARD_SH  = cprc_pkg::GUARD;

  localparam longint GAIN_FIX  = 64'sd10188014;   // 1/K in Q.24
  localparam longint HALF_TURN = 64'sd11796480;   // 180 deg in Q.16
  localparam longint QTR_TURN  = 64'sd5898240;    // 90 deg in Q.16
  localparam longint ANG_SAT   = 64'sd11520;      // 180 deg in Q.6
  localparam longint MAG_SAT   = 64'sd46341;

  localparam bit TO_POLAR = 1'b0;
  localparam bit TO_RECT  = 1'b1;

  // atan(2^-i) in degrees Q.16
  localparam longint ATAN_STEP [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    bit                 mode;
    logic signed [15:0] in_first;
    logic signed [15:0] in_second;
    logic signed [16:0] out_first;
    logic signed [15:0] out_second;
  } conversion_t;

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // drop gain and guard bits, round half up
  function automatic longint gain_round(longint v);
    return (v * GAIN_FIX + (64'sd1 <<< (24 + GUARD_SH - 1))) >>> (24 + GUARD_SH);
  endfunction

  function automatic conversion_t convert(bit mode, logic signed [15:0] a_in,
                                          logic signed [15:0] b_in);
    conversion_t r;
    longint a, b, x, y, z, dx, dy, v1, v2;
    bit flip;
    int i;
    a = a_in;
    b = b_in;
    flip = 1'b0;
    r.mode = mode;
    r.in_first = a_in;
    r.in_second = b_in;
    if (mode == TO_POLAR) begin
      if (a == 0 && b == 0) begin
        v1 = 0;
        v2 = 0;
      end else begin
        x = a <<< GUARD_SH;
        y = b <<< GUARD_SH;
        z = 0;
        // left half plane: pre-rotate by 180 deg
        if (a < 0) begin
          x = -x;
          y = -y;
          z = (b >= 0) ? HALF_TURN : -HALF_TURN;
        end
        for (i = 0; i < ROTATIONS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_STEP[i];
          end else begin
            x -= dx; y += dy; z -= ATAN_STEP[i];
          end
        end
        v1 = sat(gain_round(x), 0, MAG_SAT);
        v2 = sat((z + 512) >>> 10, -ANG_SAT, ANG_SAT);
      end
    end else begin
      z = sat(b, -ANG_SAT, ANG_SAT) * 1024;
      // fold angles beyond +-90 deg, negate at the end
      if (z > QTR_TURN) begin
        z -= HALF_TURN;
        flip = 1'b1;
      end else if (z < -QTR_TURN) begin
        z += HALF_TURN;
        flip = 1'b1;
      end
      x = a <<< GUARD_SH;
      y = 0;
      for (i = 0; i < ROTATIONS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_STEP[i];
        end else begin
          x += dx; y -= dy; z += ATAN_STEP[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      v1 = sat(gain_round(x), -MAG_SAT, MAG_SAT);
      v2 = sat(gain_round(y), -32768, 32767);
    end
    r.out_first = v1[16:0];
    r.out_second = v2[15:0];
    return r;
  endfunction

  // in-order store of predicted conversions
  class conversion_scoreboard;
    conversion_t awaited[$];
    int          mismatches = 0;
    int          matched = 0;

    function void note_input(bit mode, logic signed [15:0] in_first,
                             logic signed [15:0] in_second);
      awaited.push_back(convert(mode, in_first, in_second));
    endfunction

    function void check_result(logic [39:0] beat);
      conversion_t        want;
      logic signed [16:0] got_first;
      logic signed [15:0] got_second;
      got_first = beat[16:0];
      got_second = beat[32:17];
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: first %0d second %0d", got_first, got_second);
        return;
      end
      want = awaited.pop_front();
      if (got_first !== want.out_first || got_second !== want.out_second) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch mode %0d in (%0d, %0d): expected (%0d, %0d), got (%0d, %0d)",
                   want.mode, want.in_first, want.in_second, want.out_first,
                   want.out_second, got_first, got_second);
      end else begin
        matched++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

[bench/tb.sv]
// Top-level bench for complex_polar_rectangular_convert: drives beats on the
// input stream, paces the output stream and scores results in order.
// Depends on cprc_pkg, polar_rect_check_pkg and the converter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY      = cprc_pkg::ITER_RUN + 5;
  localparam int RANDOM_PHASE = 350;
  localparam int STALL_CYCLES = 400;
  localparam bit TO_POLAR     = polar_rect_check_pkg::TO_POLAR;
  localparam bit TO_RECT      = polar_rect_check_pkg::TO_RECT;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] in_first, [31:16] in_second
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [16:0] out_first, [32:17] out_second, [39:33] zero

  polar_rect_check_pkg::conversion_scoreboard sb;
  int src_idle_pct = 22;
  int snk_idle_pct = 66;
  bit stall_go = 1'b0;
  int n_to_polar = 0;
  int n_to_rect = 0;

  complex_polar_rectangular_convert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // offer one beat, with a random gap ahead of it, and wait for acceptance
  task automatic send_beat(input bit mode, input logic signed [15:0] first,
                           input logic signed [15:0] second);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second, first};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(mode, first, second);
    if (mode == TO_POLAR) n_to_polar++;
    else n_to_rect++;
  endtask

  // full-range values half the time, otherwise small ones and the edges
  function automatic logic signed [15:0] pick_coord();
    int k;
    int v;
    k = $urandom_range(9);
    if (k < 5) begin
      v = $urandom;
    end else if (k < 8) begin
      v = int'($urandom_range(1024)) - 512;
    end else begin
      case ($urandom_range(6))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        3: v = 1;
        4: v = -1;
        5: v = 256;
        default: v = -256;
      endcase
    end
    return v[15:0];
  endfunction

  task automatic send_random();
    bit                 mode;
    logic signed [15:0] first;
    logic signed [15:0] second;
    int                 v;
    mode = 1'($urandom_range(1));
    first = pick_coord();
    if (mode == TO_POLAR) begin
      second = pick_coord();
    end else begin
      // magnitudes mostly nonnegative, angles mostly inside +-180 deg
      if (first < 0 && $urandom_range(9) < 8) first = ~first;
      if ($urandom_range(9) < 7) begin
        v = int'($urandom_range(23040)) - 11520;
        second = v[15:0];
      end else begin
        second = pick_coord();
      end
    end
    send_beat(mode, first, second);
  endtask

  // output side: score accepted beats, pace tready, one long hold-off
  initial begin : sink
    int  hold;
    bit  stall_used;
    hold = 0;
    stall_used = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (stall_go && !stall_used) begin
        hold = STALL_CYCLES;
        stall_used = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int n;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // to polar: zero vector, axes, corners, left half plane on both sides
    send_beat(TO_POLAR, 16'sd0, 16'sd0);
    send_beat(TO_POLAR, 16'sd32767, 16'sd0);
    send_beat(TO_POLAR, -16'sd32768, 16'sd0);
    send_beat(TO_POLAR, 16'sd0, 16'sd32767);
    send_beat(TO_POLAR, 16'sd0, -16'sd32768);
    send_beat(TO_POLAR, 16'sd32767, 16'sd32767);
    send_beat(TO_POLAR, -16'sd32768, -16'sd32768);
    send_beat(TO_POLAR, -16'sd32768, 16'sd32767);
    send_beat(TO_POLAR, -16'sd256, 16'sd0);
    send_beat(TO_POLAR, -16'sd256, -16'sd1);
    send_beat(TO_POLAR, 16'sd0, 16'sd1);
    send_beat(TO_POLAR, -16'sd1, 16'sd0);
    // to rectangular: +-90 deg fold edges, angle clamping, negative magnitude
    send_beat(TO_RECT, 16'sd256, 16'sd0);
    send_beat(TO_RECT, 16'sd256, 16'sd11520);
    send_beat(TO_RECT, 16'sd256, -16'sd11520);
    send_beat(TO_RECT, 16'sd256, 16'sd5760);
    send_beat(TO_RECT, 16'sd256, 16'sd5761);
    send_beat(TO_RECT, 16'sd256, -16'sd5761);
    send_beat(TO_RECT, 16'sd32767, 16'sd32767);
    send_beat(TO_RECT, 16'sd32767, -16'sd32768);
    send_beat(TO_RECT, -16'sd32768, -16'sd5760);
    send_beat(TO_RECT, -16'sd32768, 16'sd5760);
    send_beat(TO_RECT, 16'sd32767, 16'sd2880);
    send_beat(TO_RECT, 16'sd0, 16'sd0);
    send_beat(TO_RECT, -16'sd1, -16'sd1);

    // sender mostly active, sink mostly stalled
    for (n = 0; n < RANDOM_PHASE; n++) send_random();
    // roles swapped
    src_idle_pct = 66;
    snk_idle_pct <= 22;
    for (n = 0; n < RANDOM_PHASE; n++) send_random();
    // full rate, starting with a long sink hold-off to back up the pipe
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    stall_go <= 1'b1;
    for (n = 0; n < RANDOM_PHASE; n++) send_random();
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Scored %0d conversions: %0d to polar, %0d to rectangular, %0d mismatches.",
             sb.matched, n_to_polar, n_to_rect, sb.mismatches);
    $display("Idle mixes on both sides, full rate and a %0d-cycle sink hold-off were run.",
             STALL_CYCLES);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #200_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
